>>> hdl/sds_pkg.sv
package sds_pkg;

  // Field widths that the interface fixes.
  localparam int CYL_W      = 16;
  localparam int DISK_W     = 17;
  localparam int SEEK_W     = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_POSITION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_TOWARD_HIGH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CYL_W-1:0]  HEAD_POSITION_RST  = 16'd0;
  localparam logic [DISK_W-1:0] DISK_CYLINDERS_RST = 17'd65536;

  // One request word.
  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } req_word_t;

  // One service word.
  typedef struct packed {
    logic [CYL_W-1:0]  service_cylinder;
    logic [CYL_W-1:0]  move_distance;
    logic [SEEK_W-1:0] total_seek;
    logic              last_in_run;
  } svc_word_t;

endpackage

>>> hdl/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler.
//
// Request words arrive on the in_ channel (valid/stall), one cylinder each,
// and are kept sorted in a small RAM by an insertion walk. A word with
// last_request set closes the batch: the batch is split at head_position and
// the service order goes out on the out_ channel, one word per visited
// cylinder with the move distance and the running seek total; last_in_run
// marks the final word. N requests give N + 1 words, the extra one being the
// end of the sweep.
// The single RAM read port allows one read and one compare per entry that a
// request moves past in the insertion walk. A marked word then searches for
// the split point. A low-side word is read and emitted, a high-side word is
// read, compared with the top cylinder and emitted, and the end of the sweep
// is emitted directly. Requests wait while a word is sorted or a batch is
// emitted. A stall on out_ holds the output register and pauses the
// sequence; the final word may wait there while the next batch loads. Reset
// clears the request count and restores the configuration defaults; the RAM
// needs no clearing pass. The user must write configuration only between
// batches; the block itself does not enforce this.
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sds_pkg::req_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sds_pkg::svc_word_t                 out_data,
  input  logic                               cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CYL_W  = sds_pkg::CYL_W;
  localparam int SEEK_W = sds_pkg::SEEK_W;
  localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS       = 4'd1;
  localparam logic [3:0] S_INS_CMP   = 4'd2;
  localparam logic [3:0] S_SPLIT_RD  = 4'd3;
  localparam logic [3:0] S_SPLIT_CMP = 4'd4;
  localparam logic [3:0] S_LO_RD     = 4'd5;
  localparam logic [3:0] S_LO_EM     = 4'd6;
  localparam logic [3:0] S_HI_RD     = 4'd7;
  localparam logic [3:0] S_HI_CMP    = 4'd8;
  localparam logic [3:0] S_HI_EM     = 4'd9;
  localparam logic [3:0] S_END       = 4'd10;

  // Configuration registers.
  logic [CYL_W-1:0]           head_pos_r;
  logic [sds_pkg::DISK_W-1:0] disk_cyl_r;
  logic                       toward_high_r;

  // Sequencer and datapath registers.
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  e_r, e_nxt;
  logic              placed_r, placed_nxt;
  logic [CYL_W-1:0]  req_r, req_nxt;
  logic              mark_r, mark_nxt;
  logic [CYL_W-1:0]  cur_r, cur_nxt;
  logic [SEEK_W-1:0] total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  sds_pkg::svc_word_t out_r, out_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CYL_W-1:0]  ram_wr_data;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [CYL_W-1:0]  ram_rd_data;

  // Shared subtract unit and its operands.
  logic [CYL_W-1:0]  alu_a, alu_b;
  logic [CYL_W:0]    alu_diff;
  logic              alu_borrow;
  logic [CYL_W-1:0]  move_dist;
  logic [CYL_W-1:0]  top_cyl;
  logic [CYL_W-1:0]  end_cyl;
  logic [CYL_W-1:0]  emit_cyl;
  logic              emit_state;
  logic              out_free;
  logic              emit_last;
  logic [CNT_W-1:0]  pos_m1, i_m1;

  sds_ram #(
    .WIDTH (CYL_W),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Top cylinder with the disk size clamped to 1..65536.
  always_comb begin
    if (disk_cyl_r == '0) begin
      top_cyl = '0;
    end else if (disk_cyl_r[sds_pkg::DISK_W-1]) begin
      top_cyl = '1;
    end else begin
      top_cyl = disk_cyl_r[CYL_W-1:0] - 1'b1;
    end
  end

  assign end_cyl    = toward_high_r ? top_cyl : '0;
  assign emit_state = (state_r == S_LO_EM) || (state_r == S_HI_EM) || (state_r == S_END);
  assign emit_cyl   = (state_r == S_END) ? end_cyl : ram_rd_data;
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_last  = (e_r == count_r);
  assign pos_m1     = pos_r - 1'b1;
  assign i_m1       = i_r - 1'b1;

  // Operand select for the shared subtractor.
  always_comb begin
    case (state_r)
      S_INS_CMP: begin
        alu_a = req_r;
        alu_b = ram_rd_data;
      end
      S_SPLIT_CMP: begin
        alu_a = ram_rd_data;
        alu_b = head_pos_r;
      end
      S_HI_CMP: begin
        alu_a = top_cyl;
        alu_b = ram_rd_data;
      end
      default: begin
        alu_a = emit_cyl;
        alu_b = cur_r;
      end
    endcase
  end

  // A borrow means a is below b; the magnitude gives the move distance.
  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[CYL_W];
  assign move_dist  = alu_borrow ? (~alu_diff[CYL_W-1:0] + 1'b1) : alu_diff[CYL_W-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: insertion walk, split search and emission.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    e_nxt         = e_r;
    placed_nxt    = placed_r;
    req_nxt       = req_r;
    mark_nxt      = mark_r;
    cur_nxt       = cur_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_wr_addr   = pos_r[ADDR_W-1:0];
    ram_wr_data   = req_r;
    ram_re        = 1'b0;
    ram_rd_addr   = pos_m1[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data.request_cylinder;
          mark_nxt = in_data.last_request;
          pos_nxt  = count_r;
          k_nxt    = '0;
          if (count_r != CNT_W'(MAX_REQUESTS)) begin
            state_nxt = S_INS;
          end else if (in_data.last_request) begin
            state_nxt = S_SPLIT_RD;
          end
        end
      end
      S_INS: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = mark_r ? S_SPLIT_RD : S_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (alu_borrow) begin
          // Stored entry is larger: move it up one place and keep walking.
          ram_wr_data = ram_rd_data;
          pos_nxt     = pos_m1;
          state_nxt   = S_INS;
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = mark_r ? S_SPLIT_RD : S_IDLE;
        end
      end
      S_SPLIT_RD: begin
        ram_rd_addr = k_r[ADDR_W-1:0];
        if (k_r == count_r) begin
          state_nxt = toward_high_r ? S_HI_RD : S_LO_RD;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SPLIT_CMP;
        end
        i_nxt      = k_r;
        e_nxt      = '0;
        placed_nxt = 1'b0;
        cur_nxt    = head_pos_r;
        total_nxt  = '0;
      end
      S_SPLIT_CMP: begin
        if (alu_borrow) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SPLIT_RD;
        end else begin
          i_nxt     = k_r;
          state_nxt = toward_high_r ? S_HI_RD : S_LO_RD;
        end
      end
      S_LO_RD: begin
        ram_rd_addr = i_m1[ADDR_W-1:0];
        if (i_r == '0) begin
          state_nxt = S_END;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_LO_EM;
        end
      end
      S_HI_RD: begin
        ram_rd_addr = i_r[ADDR_W-1:0];
        if (i_r == count_r) begin
          if (toward_high_r && !placed_r) begin
            state_nxt = S_END;
          end else if (toward_high_r) begin
            i_nxt     = k_r;
            state_nxt = S_LO_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_HI_CMP;
        end
      end
      S_HI_CMP: begin
        // The top cylinder goes in before the first request above it.
        if (toward_high_r && !placed_r && alu_borrow) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_HI_EM;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Emission: load the output register once it is free.
    if (emit_state) begin
      if (out_free) begin
        out_valid_nxt            = 1'b1;
        out_nxt.service_cylinder = emit_cyl;
        out_nxt.move_distance    = move_dist;
        out_nxt.total_seek       = total_r + SEEK_W'(move_dist);
        out_nxt.last_in_run      = emit_last;
        total_nxt                = total_r + SEEK_W'(move_dist);
        cur_nxt                  = emit_cyl;
        e_nxt                    = e_r + 1'b1;
        if (emit_last) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (state_r == S_LO_EM) begin
          i_nxt     = i_m1;
          state_nxt = S_LO_RD;
        end else if (state_r == S_HI_EM) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_HI_RD;
        end else if (!toward_high_r) begin
          i_nxt     = k_r;
          state_nxt = S_HI_RD;
        end else begin
          placed_nxt = 1'b1;
          if (i_r == count_r) begin
            i_nxt     = k_r;
            state_nxt = S_LO_RD;
          end else begin
            state_nxt = S_HI_EM;
          end
        end
      end else begin
        state_nxt = state_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      cur_r         <= '0;
      total_r       <= '0;
      head_pos_r    <= sds_pkg::HEAD_POSITION_RST;
      disk_cyl_r    <= sds_pkg::DISK_CYLINDERS_RST;
      toward_high_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      total_r     <= total_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sds_pkg::CFG_HEAD_POSITION:     head_pos_r    <= cfg_wdata[CYL_W-1:0];
          sds_pkg::CFG_DISK_CYLINDERS:    disk_cyl_r    <= cfg_wdata;
          sds_pkg::CFG_SWEEP_TOWARD_HIGH: toward_high_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    e_r      <= e_nxt;
    placed_r <= placed_nxt;
    req_r    <= req_nxt;
    mark_r   <= mark_nxt;
    out_r    <= out_nxt;
  end

endmodule

>>> hdl/sds_ram.sv
module sds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds while idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/sds_checker.sv
module sds_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input sds_pkg::req_word_t             in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input sds_pkg::svc_word_t             out_data
);

  // A stalled service word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("service word changed while stalled");

  // No service word right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("service word valid after reset");

  // A word that closes the batch makes the block busy in the next cycle.
  a_batch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_request |=> in_stall)
    else $error("block took a request right after a closing word");

  // The running total always covers the latest move.
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.total_seek >= 22'(out_data.move_distance))
    else $error("seek total below move distance");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (.*);
